>>> src/uit_pkg.sv
// ----------------------------------------------------------------------------
// uit_pkg: shared types and constants of the uid index table
// Holds the request and response items, command and status codes, and the
// table geometry used by the front queue and the back engine.
// ----------------------------------------------------------------------------
package uit_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SW     = CNT_W + 2;

  localparam logic [31:0] BLANK_ID = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_RESIZE  = 3'd0,
    CMD_SET_ID  = 3'd1,
    CMD_SET_LOC = 3'd2,
    CMD_EXPUNGE = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_READ    = 3'd5,
    CMD_SORT    = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RANGE       = 3'd1,
    ST_ID_REFUSED  = 3'd2,
    ST_LOC_REFUSED = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_TOO_BIG     = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [8:0]         msg_number;
    logic [31:0]        uid;
    logic signed [31:0] local_id;
    logic [8:0]         new_size;
    logic [7:0]         entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [8:0]         found_number;
    logic [31:0]        entry_uid;
    logic signed [31:0] entry_local_id;
    logic [8:0]         count;
  } rsp_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    cmd_t op;
    logic too_big;
    req_t req;
  } q_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] loc;
  } entry_t;

endpackage

>>> src/uit_front.sv
// ----------------------------------------------------------------------------
// uit_front: command intake
// Accepts items, decodes the command and flags oversize resizes, and holds
// them in a two-entry queue for the back engine.
// ----------------------------------------------------------------------------
module uit_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  uit_pkg::req_t req,
  output logic          q_valid,
  output uit_pkg::q_t   q_entry,
  input  logic          q_pop
);

  uit_pkg::q_t slot [2];
  logic        wr_sel;
  logic        rd_sel;
  logic [1:0]  fill;
  logic        push;
  uit_pkg::q_t classified;

  assign req_ready = (fill != 2'd2);
  assign push      = req_valid && req_ready;
  assign q_valid   = (fill != 2'd0);
  assign q_entry   = slot[rd_sel];

  always_comb begin
    classified.op      = uit_pkg::cmd_t'(req.cmd);
    classified.too_big = (32'(req.new_size) > uit_pkg::DEPTH);
    classified.req     = req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_sel] <= classified;
        wr_sel       <= ~wr_sel;
      end
      // advance read side on pop
      if (q_pop && q_valid) begin
        rd_sel <= ~rd_sel;
      end
      case ({push, q_pop && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> src/uit_back.sv
// ----------------------------------------------------------------------------
// uit_back: table engine
// Runs one command at a time over a single-port table memory: fills, writes,
// shifts, binary search and insertion sort, then hands the result on.
// ----------------------------------------------------------------------------
module uit_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  uit_pkg::q_t   q_entry,
  output logic          q_pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output uit_pkg::rsp_t rsp
);

  localparam int AW = uit_pkg::ADDR_W;
  localparam int CW = uit_pkg::CNT_W;
  localparam int SW = uit_pkg::SW;

  typedef enum logic [3:0] {
    S_IDLE, S_RESIZE, S_RD, S_USE, S_EXP_CHK, S_EXP_WR, S_FIND_RD, S_FIND_CHK,
    S_SORT_I, S_SORT_KEY, S_SORT_J, S_SORT_CMP, S_DONE
  } state_t;

  state_t          state;
  uit_pkg::q_t     cur;
  uit_pkg::rsp_t   pend;
  logic [CW-1:0]   count;
  logic [CW-1:0]   i;
  logic [CW-1:0]   j;
  logic [AW-1:0]   ptr;
  uit_pkg::entry_t key;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] probe;

  uit_pkg::entry_t mem [uit_pkg::DEPTH];
  uit_pkg::entry_t rdata;
  uit_pkg::entry_t wdata;
  logic            we;
  logic            re;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;

  // decode of the item at the queue head
  logic num_ok;
  logic idx_ok;
  logic [AW-1:0] num_pos;
  logic signed [SW-1:0] n_s;

  // per-state conditions
  logic id_refuse;
  logic loc_refuse;
  logic use_we;
  logic exp_more;
  logic probe_in;
  logic d_gt;
  logic sort_shift;
  logic send;
  logic signed [SW-1:0] hi_next;
  logic signed [SW-1:0] lo_next;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_adj;
  logic signed [SW-1:0] probe_next;

  assign q_pop = (state == S_IDLE) && q_valid;
  // load the output register once it is free
  assign send  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    num_ok  = (q_entry.req.msg_number != 9'd0) &&
              (32'(q_entry.req.msg_number) <= 32'(count));
    idx_ok  = (32'(q_entry.req.entry_index) < 32'(count));
    num_pos = AW'(q_entry.req.msg_number - 9'd1);
    n_s     = $signed({2'b00, count});

    id_refuse  = (rdata.id != uit_pkg::BLANK_ID) && (rdata.id != cur.req.uid);
    loc_refuse = (rdata.loc != 32'd0) && (rdata.loc != cur.req.local_id);
    use_we     = ((cur.op == uit_pkg::CMD_SET_ID) && !id_refuse) ||
                 ((cur.op == uit_pkg::CMD_SET_LOC) && !loc_refuse);
    exp_more   = (32'(ptr) + 32'd1) < 32'(count);
    probe_in   = (probe >= 0) && (probe < n_s);
    d_gt       = (rdata.id > cur.req.uid);
    sort_shift = (rdata.id > key.id);

    // next probe, midpoint truncated toward zero
    hi_next    = d_gt ? (probe - SW'(1)) : hi;
    lo_next    = d_gt ? lo : (probe + SW'(1));
    sum        = hi_next + lo_next;
    sum_adj    = sum + $signed({{(SW-1){1'b0}}, sum[SW-1]});
    probe_next = sum_adj >>> 1;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = ptr;
    raddr = ptr;
    wdata = key;
    case (state)
      S_RESIZE: begin
        we    = (32'(i) < 32'(cur.req.new_size));
        waddr = i[AW-1:0];
        wdata = '{id: uit_pkg::BLANK_ID, loc: 32'd0};
      end
      S_RD: begin
        re = 1'b1;
      end
      S_USE: begin
        we = use_we;
        if (cur.op == uit_pkg::CMD_SET_ID) begin
          wdata = '{id: cur.req.uid, loc: rdata.loc};
        end else begin
          wdata = '{id: rdata.id, loc: cur.req.local_id};
        end
      end
      S_EXP_CHK: begin
        re    = exp_more;
        raddr = ptr + AW'(1);
      end
      S_EXP_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_FIND_RD: begin
        re    = probe_in;
        raddr = probe[AW-1:0];
      end
      S_SORT_I: begin
        re    = (32'(i) < 32'(count));
        raddr = i[AW-1:0];
      end
      S_SORT_J: begin
        we    = (j == '0);
        waddr = '0;
        re    = (j != '0);
        raddr = AW'(j - CW'(1));
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = sort_shift ? rdata : key;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (send) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_entry;
            case (q_entry.op)
              uit_pkg::CMD_RESIZE: begin
                if (q_entry.too_big) begin
                  pend.status <= uit_pkg::ST_TOO_BIG;
                  state       <= S_DONE;
                end else begin
                  i     <= count;
                  state <= S_RESIZE;
                end
              end
              uit_pkg::CMD_SET_ID, uit_pkg::CMD_SET_LOC: begin
                if (!num_ok) begin
                  pend.status <= uit_pkg::ST_RANGE;
                  state       <= S_DONE;
                end else begin
                  ptr   <= num_pos;
                  state <= S_RD;
                end
              end
              uit_pkg::CMD_EXPUNGE: begin
                if (!num_ok) begin
                  pend.status <= uit_pkg::ST_RANGE;
                  state       <= S_DONE;
                end else begin
                  ptr   <= num_pos;
                  state <= S_EXP_CHK;
                end
              end
              uit_pkg::CMD_FIND: begin
                if (count == '0) begin
                  pend.status <= uit_pkg::ST_EMPTY;
                  state       <= S_DONE;
                end else begin
                  lo    <= '0;
                  hi    <= n_s - SW'(1);
                  probe <= (n_s - SW'(1)) >>> 1;
                  state <= S_FIND_RD;
                end
              end
              uit_pkg::CMD_READ: begin
                if (!idx_ok) begin
                  pend.status <= uit_pkg::ST_RANGE;
                  state       <= S_DONE;
                end else begin
                  ptr   <= AW'(q_entry.req.entry_index);
                  state <= S_RD;
                end
              end
              uit_pkg::CMD_SORT: begin
                i     <= CW'(1);
                state <= S_SORT_I;
              end
              uit_pkg::CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RESIZE: begin
          if (32'(i) < 32'(cur.req.new_size)) begin
            i <= i + CW'(1);
          end else begin
            count <= CW'(cur.req.new_size);
            state <= S_DONE;
          end
        end
        S_RD: begin
          state <= S_USE;
        end
        S_USE: begin
          case (cur.op)
            uit_pkg::CMD_SET_ID: begin
              if (id_refuse) begin
                pend.status <= uit_pkg::ST_ID_REFUSED;
              end
            end
            uit_pkg::CMD_SET_LOC: begin
              if (loc_refuse) begin
                pend.status <= uit_pkg::ST_LOC_REFUSED;
              end
            end
            default: begin
              pend.entry_uid      <= rdata.id;
              pend.entry_local_id <= $signed(rdata.loc);
            end
          endcase
          state <= S_DONE;
        end
        S_EXP_CHK: begin
          if (exp_more) begin
            state <= S_EXP_WR;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_EXP_WR: begin
          ptr   <= ptr + AW'(1);
          state <= S_EXP_CHK;
        end
        S_FIND_RD: begin
          state <= probe_in ? S_FIND_CHK : S_DONE;
        end
        S_FIND_CHK: begin
          if (rdata.id == cur.req.uid) begin
            pend.found_number <= 9'(probe + SW'(1));
            state             <= S_DONE;
          end else if (lo > hi) begin
            state <= S_DONE;
          end else begin
            hi    <= hi_next;
            lo    <= lo_next;
            probe <= probe_next;
            state <= S_FIND_RD;
          end
        end
        S_SORT_I: begin
          state <= (32'(i) < 32'(count)) ? S_SORT_KEY : S_DONE;
        end
        S_SORT_KEY: begin
          key   <= rdata;
          j     <= i;
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          if (j == '0) begin
            i     <= i + CW'(1);
            state <= S_SORT_I;
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (sort_shift) begin
            j     <= j - CW'(1);
            state <= S_SORT_J;
          end else begin
            i     <= i + CW'(1);
            state <= S_SORT_I;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (send) begin
            rsp   <= '{status:         pend.status,
                       found_number:   pend.found_number,
                       entry_uid:      pend.entry_uid,
                       entry_local_id: pend.entry_local_id,
                       count:          9'(count)};
            pend  <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/uid_index_table.sv
// ----------------------------------------------------------------------------
// uid_index_table: command-driven table of unique ids and local ids
// Resize, write-once field updates, expunge, binary-search find, read,
// stable sort and clear over a table of up to DEPTH entries.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload           direction
//   -------   -------------------   ---------------   ---------
//   request   req_valid/req_ready   req (req_t)       in
//   response  rsp_valid/rsp_ready   rsp (rsp_t)       out
//
// Work per item, set by the single-port table memory (one access a cycle):
//   clear and commands refused at decode touch no entry; set id and set
//   local id read one entry and write it unless refused; read reads one;
//   resize writes each entry added; expunge moves each later entry down;
//   find reads one entry per probe; sort shifts each larger element up.
// Reset clears the entry count, the queue and the response valid; the
// table memory is not cleared and is only read below the count.
// A two-entry queue keeps taking items while the engine works; a waiting
// response stalls the engine, and the intake only once the queue is full.
// ----------------------------------------------------------------------------
module uid_index_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  uit_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output uit_pkg::rsp_t rsp
);

  logic        q_valid;
  logic        q_pop;
  uit_pkg::q_t q_entry;

  // intake: decode and queue
  uit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // engine: table memory and command sequencing
  uit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // no response right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // a hit lies within the table and carries ok status
  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found_number != 9'd0) |->
      (rsp.status == 3'(uit_pkg::ST_OK) && rsp.found_number <= rsp.count))
    else $error("find hit outside table");

  // an empty report only comes from an empty table
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == 3'(uit_pkg::ST_EMPTY)) |-> (rsp.count == 9'd0))
    else $error("empty status with nonzero count");

  // count never exceeds the table depth
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.count) <= uit_pkg::DEPTH))
    else $error("entry count above depth");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the uid index table
// Runs a directed sweep of corner cases, then random table sessions
// (resize, fill, sort, search, read, expunge) mixed with noise commands.
// Every response is checked field by field against an in-bench table model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_RANDOM   = 1350;
  localparam int WDOG_LIMIT = 400000;
  localparam int MAX_SHOWN  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  uit_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  uit_pkg::rsp_t rsp;

  // Stimulus waiting for the driver, and responses owed by the table
  uit_pkg::req_t pend_q[$];
  uit_pkg::rsp_t owed_q[$];

  // Bench copy of the table contents
  logic [31:0] id_tab[uit_pkg::DEPTH];
  logic [31:0] loc_tab[uit_pkg::DEPTH];
  int unsigned tab_cnt;

  int n_sent;
  int n_got;
  int n_err;
  int n_found_hits;
  int wdog;
  int big_left;
  int gen_cnt;
  logic [31:0] uid_pool[$];

  uid_index_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table model: apply one command, return the response it owes
  // --------------------------------------------------------------------------
  function automatic uit_pkg::rsp_t table_apply(uit_pkg::req_t r);
    uit_pkg::rsp_t o;
    int unsigned p;
    logic num_ok;
    int n, hi, lo, pr;
    logic [31:0] kid, kloc;
    int j;
    o = '0;
    num_ok = (r.msg_number >= 1) && (r.msg_number <= tab_cnt);
    p = num_ok ? r.msg_number - 1 : 0;
    case (uit_pkg::cmd_t'(r.cmd))
      uit_pkg::CMD_RESIZE: begin
        if (r.new_size > uit_pkg::DEPTH) begin
          o.status = uit_pkg::ST_TOO_BIG;
        end else begin
          for (int i = tab_cnt; i < r.new_size; i++) begin
            id_tab[i]  = uit_pkg::BLANK_ID;
            loc_tab[i] = '0;
          end
          tab_cnt = r.new_size;
        end
      end
      uit_pkg::CMD_SET_ID: begin
        if (!num_ok) o.status = uit_pkg::ST_RANGE;
        else if (id_tab[p] != uit_pkg::BLANK_ID && id_tab[p] != r.uid)
          o.status = uit_pkg::ST_ID_REFUSED;
        else id_tab[p] = r.uid;
      end
      uit_pkg::CMD_SET_LOC: begin
        if (!num_ok) o.status = uit_pkg::ST_RANGE;
        else if (loc_tab[p] != '0 && loc_tab[p] != r.local_id)
          o.status = uit_pkg::ST_LOC_REFUSED;
        else loc_tab[p] = r.local_id;
      end
      uit_pkg::CMD_EXPUNGE: begin
        if (!num_ok) begin
          o.status = uit_pkg::ST_RANGE;
        end else begin
          // shift the tail down over the removed entry
          for (int i = p; i + 1 < tab_cnt; i++) begin
            id_tab[i]  = id_tab[i + 1];
            loc_tab[i] = loc_tab[i + 1];
          end
          tab_cnt--;
        end
      end
      uit_pkg::CMD_FIND: begin
        if (tab_cnt == 0) begin
          o.status = uit_pkg::ST_EMPTY;
        end else begin
          // fixed probe sequence, midpoint truncated toward zero
          n  = tab_cnt;
          hi = n - 1;
          lo = 0;
          pr = hi / 2;
          while (1) begin
            if (pr < 0 || pr >= n) begin
              pr = -1;
              break;
            end
            if (id_tab[pr] == r.uid || lo > hi) break;
            if (id_tab[pr] > r.uid) begin
              pr--;
              hi = pr;
            end else begin
              pr++;
              lo = pr;
            end
            pr = (hi + lo) / 2;
          end
          if (pr >= 0 && id_tab[pr] == r.uid) o.found_number = 9'(pr + 1);
        end
      end
      uit_pkg::CMD_READ: begin
        if (r.entry_index >= tab_cnt) begin
          o.status = uit_pkg::ST_RANGE;
        end else begin
          o.entry_uid      = id_tab[r.entry_index];
          o.entry_local_id = loc_tab[r.entry_index];
        end
      end
      uit_pkg::CMD_SORT: begin
        // stable insertion sort on unsigned id
        for (int i = 1; i < tab_cnt; i++) begin
          kid  = id_tab[i];
          kloc = loc_tab[i];
          j = i;
          while (j > 0 && id_tab[j - 1] > kid) begin
            id_tab[j]  = id_tab[j - 1];
            loc_tab[j] = loc_tab[j - 1];
            j--;
          end
          id_tab[j]  = kid;
          loc_tab[j] = kloc;
        end
      end
      default: tab_cnt = 0;
    endcase
    o.count = 9'(tab_cnt);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Queue one command; a negative msg, nsz or idx draws a random field (nsz an oversized one)
  task automatic put(uit_pkg::cmd_t c, int msg, logic [31:0] u, logic [31:0] l, int nsz,
                     int idx);
    uit_pkg::req_t r;
    r.cmd         = c;
    r.msg_number  = (msg < 0) ? 9'($urandom) : 9'(msg);
    r.uid         = u;
    r.local_id    = l;
    r.new_size    = (nsz < 0) ? 9'($urandom_range(257, 511)) : 9'(nsz);
    r.entry_index = (idx < 0) ? 8'($urandom) : 8'(idx);
    pend_q.push_back(r);
  endtask

  function automatic logic [31:0] pick_uid();
    if (uid_pool.size() != 0 && $urandom_range(0, 2) == 0)
      return uid_pool[$urandom_range(0, uid_pool.size() - 1)];
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return uit_pkg::BLANK_ID - 32'd1;
      2: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_loc();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One well-formed session: size the table, fill it, usually sort, then probe it
  task automatic run_session();
    int n, k, steps;
    logic [31:0] u;
    uid_pool.delete();
    if (big_left > 0 && $urandom_range(0, 49) == 0) begin
      big_left--;
      n = $urandom_range(200, uit_pkg::DEPTH);
      k = $urandom_range(8, 24);
    end else begin
      n = $urandom_range(1, 16);
      k = n;
    end
    if ($urandom_range(0, 3) != 0) put(uit_pkg::CMD_CLEAR, -1, $urandom, $urandom, 0, -1);
    put(uit_pkg::CMD_RESIZE, -1, $urandom, $urandom, n, -1);
    gen_cnt = n;
    repeat (k) begin
      u = pick_uid();
      uid_pool.push_back(u);
      put(uit_pkg::CMD_SET_ID, $urandom_range(1, n), u, $urandom, 0, -1);
      if ($urandom_range(0, 1))
        put(uit_pkg::CMD_SET_LOC, $urandom_range(1, n), $urandom, pick_loc(), 0, -1);
    end
    if ($urandom_range(0, 9) != 0) put(uit_pkg::CMD_SORT, -1, $urandom, $urandom, 0, -1);
    steps = $urandom_range(4, 12);
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: put(uit_pkg::CMD_FIND, -1, pick_uid(), $urandom, 0, -1);
        4, 5: put(uit_pkg::CMD_READ, -1, $urandom, $urandom, 0,
                  $urandom_range(0, gen_cnt + 1));
        6: begin
          put(uit_pkg::CMD_EXPUNGE, $urandom_range(0, gen_cnt + 1), $urandom, $urandom, 0,
              -1);
          if (gen_cnt > 0) gen_cnt--;
        end
        7: put(uit_pkg::CMD_SET_ID, $urandom_range(0, gen_cnt + 1), pick_uid(), $urandom, 0,
               -1);
        8: put(uit_pkg::CMD_SET_LOC, $urandom_range(0, gen_cnt + 1), $urandom, pick_loc(), 0,
               -1);
        default: put(uit_pkg::CMD_SORT, -1, $urandom, $urandom, 0, -1);
      endcase
    end
  endtask

  // Broken or random commands; resize stays small or oversized
  task automatic run_noise();
    uit_pkg::cmd_t c;
    c = uit_pkg::cmd_t'($urandom_range(0, 7));
    if (c == uit_pkg::CMD_RESIZE && $urandom_range(0, 1))
      put(c, -1, $urandom, $urandom, -1, -1);
    else put(c, -1, $urandom, $urandom, $urandom_range(0, 24), -1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random sessions
  // --------------------------------------------------------------------------
  initial begin
    big_left = 4;
    // empty table
    put(uit_pkg::CMD_RESIZE, -1, '0, '0, 0, -1);
    put(uit_pkg::CMD_FIND, -1, uit_pkg::BLANK_ID, '0, 0, -1);
    put(uit_pkg::CMD_READ, -1, '0, '0, 0, 0);
    put(uit_pkg::CMD_SET_ID, 0, 32'h1234, '0, 0, -1);
    // oversized resize is refused
    put(uit_pkg::CMD_RESIZE, -1, '0, '0, uit_pkg::DEPTH + 1, -1);
    put(uit_pkg::CMD_RESIZE, -1, '0, '0, 511, -1);
    // write-once fields on a small table
    put(uit_pkg::CMD_RESIZE, -1, '0, '0, 4, -1);
    put(uit_pkg::CMD_SET_ID, 1, 32'h0000_0050, '0, 0, -1);
    put(uit_pkg::CMD_SET_ID, 1, 32'h0000_0050, '0, 0, -1);
    put(uit_pkg::CMD_SET_ID, 1, 32'h0000_0007, '0, 0, -1);
    put(uit_pkg::CMD_SET_LOC, 1, '0, 32'hFFFF_FFFF, 0, -1);
    put(uit_pkg::CMD_SET_LOC, 1, '0, 32'hFFFF_FFFF, 0, -1);
    put(uit_pkg::CMD_SET_LOC, 1, '0, 32'h0, 0, -1);
    put(uit_pkg::CMD_SET_ID, 3, 32'h0000_0002, '0, 0, -1);
    put(uit_pkg::CMD_SET_ID, 5, 32'h0000_0002, '0, 0, -1);
    put(uit_pkg::CMD_EXPUNGE, 2, '0, '0, 0, -1);
    put(uit_pkg::CMD_SORT, -1, '0, '0, 0, -1);
    put(uit_pkg::CMD_FIND, -1, 32'h0000_0050, '0, 0, -1);
    put(uit_pkg::CMD_FIND, -1, 32'h0000_0003, '0, 0, -1);
    put(uit_pkg::CMD_READ, -1, '0, '0, 0, 1);
    put(uit_pkg::CMD_CLEAR, -1, '0, '0, 0, -1);
    // full table: top message number and top read index
    put(uit_pkg::CMD_RESIZE, -1, '0, '0, uit_pkg::DEPTH, -1);
    put(uit_pkg::CMD_SET_ID, uit_pkg::DEPTH, 32'h0, 32'h7FFF_FFFF, 0, -1);
    put(uit_pkg::CMD_SET_LOC, uit_pkg::DEPTH, '0, 32'h8000_0000, 0, -1);
    put(uit_pkg::CMD_READ, -1, '0, '0, 0, 255);
    put(uit_pkg::CMD_FIND, -1, uit_pkg::BLANK_ID, '0, 0, -1);
    put(uit_pkg::CMD_EXPUNGE, uit_pkg::DEPTH, '0, '0, 0, -1);
    put(uit_pkg::CMD_EXPUNGE, 0, '0, '0, 0, -1);
    put(uit_pkg::CMD_CLEAR, -1, '0, '0, 0, -1);

    while (pend_q.size() < N_RANDOM) begin
      if ($urandom_range(0, 5) == 0) run_noise();
      else run_session();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all items taken, all responses back, then settle
    wait (pend_q.size() == 0 && !req_valid && owed_q.size() == 0);
    repeat (200) @(posedge clk);
    if (owed_q.size() != 0) n_err++;
    $display("Sent %0d commands, checked %0d responses, %0d found by search, %0d errors",
             n_sent, n_got, n_found_hits, n_err);
    $display("Covered resize, write-once set id/local id, expunge, find, read, sort, clear");
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Skip idling through a long stretch in the middle of the run
  function automatic logic stall_now(int done);
    if (done >= 500 && done < 750) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on acceptance, then present the next item or idle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        owed_q.push_back(table_apply(req));
        n_sent++;
      end
      // hold a pending item until it is taken
      if (!req_valid || req_ready) begin
        if (pend_q.size() != 0 && !stall_now(n_sent)) begin
          req       <= pend_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each response with the oldest one owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    uit_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_got++;
        if (owed_q.size() == 0) begin
          n_err++;
          if (n_err <= MAX_SHOWN) $display("Unexpected response %p", rsp);
        end else begin
          want = owed_q.pop_front();
          if (want.found_number != 0) n_found_hits++;
          if (rsp.status !== want.status || rsp.found_number !== want.found_number ||
              rsp.entry_uid !== want.entry_uid ||
              rsp.entry_local_id !== want.entry_local_id || rsp.count !== want.count) begin
            n_err++;
            if (n_err <= MAX_SHOWN)
              $display("Mismatch on response %0d: expected %p, got %p", n_got, want, rsp);
          end
        end
      end
      rsp_ready <= !stall_now(n_got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", wdog);
      $display("Verification failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

endmodule
